FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files that carry checks; only the top-level unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

FILE: hw/rtl/sidau_pkg.sv
`timescale 1ns / 1ps

package sidau_pkg;

	localparam int ValueW      = 32;
	localparam int NumDigits   = 10;
	localparam int DigitW      = 4;
	localparam int DigitIdxW   = $clog2(NumDigits);
	localparam int CharW       = 8;
	localparam int BitsPerStep = 4;
	localparam int ConvSteps   = ValueW / BitsPerStep;
	localparam int StepCntW    = $clog2(ConvSteps);
	localparam int QueueDepth  = 2;
	localparam int QueuePtrW   = $clog2(QueueDepth);
	localparam int QueueCntW   = $clog2(QueueDepth + 1);

	localparam logic [CharW-1:0]  CharZero  = 8'd48;
	localparam logic [CharW-1:0]  CharMinus = 8'd45;
	localparam logic [DigitW-1:0] DabbleMin = 4'd5;
	localparam logic [DigitW-1:0] DabbleAdd = 4'd3;

	typedef logic [NumDigits-1:0][DigitW-1:0] digits_t;

	// One converted number: sign flag and unsigned BCD magnitude.
	typedef struct packed {
		logic    neg;
		digits_t digits;
	} item_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} fstate_t;

	typedef enum logic {
		B_IDLE,
		B_EMIT
	} bstate_t;

endpackage

FILE: hw/rtl/sidau_front.sv
`timescale 1ns / 1ps

module sidau_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic signed [sidau_pkg::ValueW-1:0] s_tdata,
	output logic                                push_valid,
	input  logic                                push_ready,
	output sidau_pkg::item_t                    push_item
);
	import sidau_pkg::*;

	fstate_t                   state_q, state_d;
	logic [StepCntW-1:0]       step_q;
	logic [ValueW-1:0]         mag_q;
	digits_t                   bcd_q;
	logic                      neg_q;
	logic                      take;
	logic [ValueW-1:0]         mag_nx;
	digits_t                   bcd_nx;
	logic [ValueW-1:0]         raw;

	// Shift-and-add-three conversion, four magnitude bits per cycle.
	always_comb begin
		mag_nx = mag_q;
		bcd_nx = bcd_q;
		for (int i = 0; i < BitsPerStep; i++) begin
			for (int d = 0; d < NumDigits; d++) begin
				if (bcd_nx[d] >= DabbleMin) begin
					bcd_nx[d] = bcd_nx[d] + DabbleAdd;
				end
			end
			{bcd_nx, mag_nx} = {bcd_nx, mag_nx} << 1;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		push_valid = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				s_tready = 1'b1;
			end
			F_CONV: begin
				if (step_q == StepCntW'(ConvSteps - 1)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				push_valid = 1'b1;
				s_tready   = push_ready;
				if (push_ready) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
		take = s_tvalid && s_tready;
		if (take) begin
			state_d = F_CONV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (take) begin
				step_q <= '0;
			end else if (state_q == F_CONV) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign raw = ValueW'(s_tdata);

	always_ff @(posedge clk) begin
		if (take) begin
			neg_q <= raw[ValueW-1];
			mag_q <= raw[ValueW-1] ? (~raw + 1'b1) : raw;
			bcd_q <= '0;
		end else if (state_q == F_CONV) begin
			mag_q <= mag_nx;
			bcd_q <= bcd_nx;
		end
	end

	assign push_item.neg    = neg_q;
	assign push_item.digits = bcd_q;

endmodule

FILE: hw/rtl/sidau_fifo.sv
`timescale 1ns / 1ps

module sidau_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  sidau_pkg::item_t wr_item,
	output logic             rd_valid,
	input  logic             rd_ready,
	output sidau_pkg::item_t rd_item
);
	import sidau_pkg::*;

	item_t                mem [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueueCntW-1:0] cnt_q;
	logic                 do_wr;
	logic                 do_rd;

	assign wr_ready = (cnt_q != QueueCntW'(QueueDepth));
	assign rd_valid = (cnt_q != '0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_item  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/sidau_back.sv
`timescale 1ns / 1ps

module sidau_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pop_valid,
	output logic                            pop_ready,
	input  sidau_pkg::item_t                pop_item,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sidau_pkg::CharW-1:0]     m_tdata,
	output logic                            m_tlast
);
	import sidau_pkg::*;

	bstate_t              state_q, state_d;
	digits_t              digits_q;
	logic                 sign_q;
	logic [DigitIdxW-1:0] pos_q;
	logic [DigitIdxW-1:0] msd;
	logic                 adv;
	logic                 emit;
	logic                 final_char;
	logic                 load;
	logic                 out_valid_q;
	logic [CharW-1:0]     out_char_q;
	logic                 out_last_q;

	// Highest non-zero digit; zero keeps a single digit.
	always_comb begin
		msd = '0;
		for (int d = 0; d < NumDigits; d++) begin
			if (pop_item.digits[d] != '0) begin
				msd = DigitIdxW'(d);
			end
		end
	end

	assign adv        = !out_valid_q || m_tready;
	assign final_char = !sign_q && (pos_q == '0);

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		pop_ready = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				pop_ready = 1'b1;
			end
			B_EMIT: begin
				emit = adv;
				if (adv && final_char) begin
					pop_ready = 1'b1;
					state_d   = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
		load = pop_valid && pop_ready;
		if (load) begin
			state_d = B_EMIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (sign_q) begin
				out_char_q <= CharMinus;
				out_last_q <= 1'b0;
			end else begin
				out_char_q <= CharZero + CharW'(digits_q[pos_q]);
				out_last_q <= (pos_q == '0);
			end
		end
		if (load) begin
			digits_q <= pop_item.digits;
			sign_q   <= pop_item.neg;
			pos_q    <= msd;
		end else if (emit) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else if (pos_q != '0) begin
				pos_q <= pos_q - 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps

// Signed 32-bit integer to decimal ASCII text. Each beat accepted on the slave
// stream carries one two's complement value; the master stream returns its
// decimal text one character per beat, most significant digit first, with a
// leading '-' for negative values, no leading zeros, a single '0' for zero and
// tlast set on the final character, so a number gives from 1 to 11 beats. The
// most negative value gives "-2147483648". Timing: the front end runs the
// shift-and-add-three conversion (four magnitude bits per cycle) and then hands
// the result to a two-entry queue; it takes a new value only once the previous
// result enters the queue. The back end sends one character per cycle when the
// downstream side is ready, and the two halves stall independently through the
// queue. There are no configuration registers and reset needs no clearing pass.

module signed_int_to_decimal_ascii_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// Fields from bit 0 up: value (32 bits, signed).
	input  logic signed [sidau_pkg::ValueW-1:0] s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// Fields from bit 0 up: character (8 bits).
	output logic [sidau_pkg::CharW-1:0]         m_tdata,
	output logic                                m_tlast
);
	import sidau_pkg::*;

`include "assert_macros.svh"

	// Hand-off between the converter and the queue.
	logic  push_valid;
	logic  push_ready;
	item_t push_item;

	// Hand-off between the queue and the character emitter.
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	// Front end: takes the value, forms sign and magnitude, and converts the
	// magnitude to ten BCD digits.
	sidau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	// Short queue so that conversion and emission stall on their own.
	sidau_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(push_valid),
		.wr_ready(push_ready),
		.wr_item (push_item),
		.rd_valid(pop_valid),
		.rd_ready(pop_ready),
		.rd_item (pop_item)
	);

	// Back end: skips leading zeros and sends the sign and digits through a
	// registered output stage.
	sidau_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item (pop_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Every character sent is a minus sign or a decimal digit.
	`ASSERT_SAME(a_char_legal, clk, arst_n, m_tvalid,
		(m_tdata == CharMinus) || ((m_tdata >= CharZero) && (m_tdata <= CharZero + 8'd9)))

	// A minus sign is never the last character of a number.
	`ASSERT_SAME(a_minus_not_last, clk, arst_n, m_tvalid && (m_tdata == CharMinus), !m_tlast)

	// A converted number waiting for queue space is held until it is taken.
	`ASSERT_NEXT(a_push_held, clk, arst_n, push_valid && !push_ready,
		push_valid && $stable(push_item))

	// The converter never accepts a new value while its result is refused.
	`ASSERT_SAME(a_no_take_on_stall, clk, arst_n, push_valid && !push_ready, !s_tready)

endmodule
